>>> rtl/core/psb_pkg.sv
// Shared types and constants for the downward prime search block.
package psb_pkg;

    localparam int VALUE_BITS = 31;
    localparam int COUNT_BITS = 7;
    localparam int MAX_PRIMES = 64;

    // Trial divisors stay near the square root of the candidate.
    localparam int DIV_BITS = (VALUE_BITS + 1) / 2 + 2;
    // Running square of (divisor - 1), with headroom for one step past the candidate.
    localparam int SQ_BITS  = VALUE_BITS + 2;
    localparam int IDX_BITS = $clog2(VALUE_BITS);

    typedef struct packed {
        logic [VALUE_BITS-1:0] start_value;
        logic [COUNT_BITS-1:0] prime_count;
    } psb_item_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] prime_value;
        logic                  has_prime;
        logic                  last_of_run;
        logic                  shortfall;
    } psb_result_t;

endpackage

>>> rtl/core/prime_search_below_bound.sv
// Downward prime search by trial division with one shared bit-serial remainder unit.
//
// A transaction is taken at a rising edge where start is high and busy is low; item holds
// the bound start_value and the wanted prime_count (saturated at the package maximum).
// Odd candidates are tested downward from just below the bound. Each prime found is sent
// on result for exactly one cycle, marked by result_valid, largest first; the final result
// of a transaction has last_of_run set, and shortfall when the candidates ran out first.
// A result without a prime (has_prime low, prime_value zero) is given when nothing was found.
// Counts of zero, a bound of one or zero are answered in the cycle after acceptance
// without raising busy. Otherwise busy stays high until the final result has been sent.
// Each trial division runs through a restoring shift-subtract unit, one bit of the
// candidate per cycle. The time a transaction takes depends on the prime gaps below
// the bound. A prime is held back until the next prime is found or the search ends,
// so that the last one can be flagged.
// Reset returns the sequencer to idle with no result pending.
// The receiver cannot stall: each result is present for one cycle only.
module prime_search_below_bound (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  psb_pkg::psb_item_t    item,
    output logic                  busy,
    output logic                  result_valid,
    output psb_pkg::psb_result_t  result
);

    localparam int VB  = psb_pkg::VALUE_BITS;
    localparam int CB  = psb_pkg::COUNT_BITS;
    localparam int DB  = psb_pkg::DIV_BITS;
    localparam int SB  = psb_pkg::SQ_BITS;
    localparam int IB  = psb_pkg::IDX_BITS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TEST,
        ST_DIV,
        ST_CHECK,
        ST_NEXT,
        ST_LAST
    } state_t;

    state_t                state_reg, state_next;
    logic [VB-1:0]         cand_reg, cand_next;
    logic [DB-1:0]         div_reg, div_next;
    logic [SB-1:0]         sq_reg, sq_next;
    logic [DB-1:0]         rem_reg, rem_next;
    logic [IB-1:0]         idx_reg, idx_next;
    logic [CB-1:0]         found_reg, found_next;
    logic [CB-1:0]         want_reg, want_next;
    logic [VB-1:0]         pend_reg, pend_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic                  short_reg, short_next;
    logic                  result_valid_reg, result_valid_next;
    psb_pkg::psb_result_t  result_reg, result_next;

    logic [CB-1:0]         want_sat;
    logic [DB:0]           rem_shift;
    logic [DB:0]           rem_sub;
    logic                  rem_ge;
    logic [CB-1:0]         found_inc;

    assign want_sat  = (item.prime_count > CB'(psb_pkg::MAX_PRIMES))
                       ? CB'(psb_pkg::MAX_PRIMES) : item.prime_count;
    assign rem_shift = {rem_reg, cand_reg[idx_reg]};
    assign rem_ge    = rem_shift >= {1'b0, div_reg};
    assign rem_sub   = rem_shift - {1'b0, div_reg};
    assign found_inc = found_reg + CB'(1);

    always_comb
    begin
        state_next        = state_reg;
        cand_next         = cand_reg;
        div_next          = div_reg;
        sq_next           = sq_reg;
        rem_next          = rem_reg;
        idx_next          = idx_reg;
        found_next        = found_reg;
        want_next         = want_reg;
        pend_next         = pend_reg;
        pend_valid_next   = pend_valid_reg;
        short_next        = short_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    want_next       = want_sat;
                    found_next      = '0;
                    pend_valid_next = 1'b0;
                    if (want_sat == '0)
                    begin
                        result_valid_next = 1'b1;
                        result_next       = '{prime_value: '0, has_prime: 1'b0,
                                              last_of_run: 1'b1, shortfall: 1'b0};
                    end
                    else if (item.start_value == VB'(1) && want_sat == CB'(1))
                    begin
                        result_valid_next = 1'b1;
                        result_next       = '{prime_value: VB'(1), has_prime: 1'b1,
                                              last_of_run: 1'b1, shortfall: 1'b0};
                    end
                    else if (item.start_value < VB'(2))
                    begin
                        result_valid_next = 1'b1;
                        result_next       = '{prime_value: '0, has_prime: 1'b0,
                                              last_of_run: 1'b1, shortfall: 1'b1};
                    end
                    else
                    begin
                        // Largest odd value strictly below the bound.
                        cand_next  = item.start_value - VB'(1) - VB'(item.start_value[0]);
                        div_next   = DB'(3);
                        sq_next    = SB'(4);
                        state_next = ST_TEST;
                    end
                end
            end

            ST_TEST:
            begin
                if (cand_reg < VB'(2))
                begin
                    state_next = ST_NEXT;
                end
                else if (sq_reg < SB'(cand_reg))
                begin
                    rem_next   = '0;
                    idx_next   = IB'(VB - 1);
                    state_next = ST_DIV;
                end
                else
                begin
                    // Prime: release the one held back, hold this one.
                    if (pend_valid_reg)
                    begin
                        result_valid_next = 1'b1;
                        result_next       = '{prime_value: pend_reg, has_prime: 1'b1,
                                              last_of_run: 1'b0, shortfall: 1'b0};
                    end
                    pend_next       = cand_reg;
                    pend_valid_next = 1'b1;
                    found_next      = found_inc;
                    if (found_inc >= want_reg)
                    begin
                        short_next = 1'b0;
                        state_next = ST_LAST;
                    end
                    else
                    begin
                        state_next = ST_NEXT;
                    end
                end
            end

            ST_DIV:
            begin
                rem_next = rem_ge ? rem_sub[DB-1:0] : rem_shift[DB-1:0];
                idx_next = idx_reg - IB'(1);
                if (idx_reg == '0)
                begin
                    state_next = ST_CHECK;
                end
            end

            ST_CHECK:
            begin
                if (rem_reg == '0)
                begin
                    state_next = ST_NEXT;
                end
                else
                begin
                    // (d + 1)^2 = (d - 1)^2 + 4d
                    sq_next    = sq_reg + SB'({div_reg, 2'b00});
                    div_next   = div_reg + DB'(2);
                    state_next = ST_TEST;
                end
            end

            ST_NEXT:
            begin
                if (cand_reg <= VB'(2))
                begin
                    short_next = 1'b1;
                    state_next = ST_LAST;
                end
                else
                begin
                    cand_next  = cand_reg - VB'(2);
                    div_next   = DB'(3);
                    sq_next    = SB'(4);
                    state_next = ST_TEST;
                end
            end

            ST_LAST:
            begin
                result_valid_next = 1'b1;
                if (pend_valid_reg)
                begin
                    result_next = '{prime_value: pend_reg, has_prime: 1'b1,
                                    last_of_run: 1'b1, shortfall: short_reg};
                end
                else
                begin
                    result_next = '{prime_value: '0, has_prime: 1'b0,
                                    last_of_run: 1'b1, shortfall: 1'b1};
                end
                pend_valid_next = 1'b0;
                state_next      = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            found_reg        <= '0;
            pend_valid_reg   <= 1'b0;
            short_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
            cand_reg         <= '0;
            div_reg          <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            found_reg        <= found_next;
            pend_valid_reg   <= pend_valid_next;
            short_reg        <= short_next;
            result_valid_reg <= result_valid_next;
            cand_reg         <= cand_next;
            div_reg          <= div_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg     <= sq_next;
        rem_reg    <= rem_next;
        idx_reg    <= idx_next;
        want_reg   <= want_next;
        pend_reg   <= pend_next;
        result_reg <= result_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

>>> rtl/core/psb_checker.sv
// Port-level checks for the prime search block, bound to its top level.
module psb_checker (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  psb_pkg::psb_item_t    item,
    input  logic                  busy,
    input  logic                  result_valid,
    input  psb_pkg::psb_result_t  result
);

    // An accepted transaction either starts a search or answers at once.
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy || result_valid)
        else $error("accepted transaction produced neither busy nor a result");

    // Finishing a search always delivers its final result.
    a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> result_valid && result.last_of_run)
        else $error("search ended without a final result");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.has_prime |-> result.last_of_run && result.prime_value == '0)
        else $error("result without a prime is not a zero final result");

    a_shortfall_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.shortfall |-> result.last_of_run)
        else $error("shortfall flagged on a non-final result");

    // No results trail after the final one while the block sits idle.
    a_no_trailing: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last_of_run && !start |=> !result_valid)
        else $error("result delivered after the final result");

endmodule

bind prime_search_below_bound psb_checker u_psb_checker (.*);

>>> tb/tb.sv
// Testbench for the downward prime search block, checked against a trial-division predictor.
module tb;

    localparam int VALUE_BITS  = psb_pkg::VALUE_BITS;
    localparam int COUNT_BITS  = psb_pkg::COUNT_BITS;
    localparam int MAX_PRIMES  = psb_pkg::MAX_PRIMES;
    localparam int GAP_MAX     = 5;
    localparam int MAX_REPORTS = 10;
    localparam int TAIL_CYCLES = 200;
    localparam int DIV_COST    = VALUE_BITS + 2;

    typedef struct {
        psb_pkg::psb_item_t req;
        int                 gap;
        bit                 drain;
    } queued_req_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    psb_pkg::psb_item_t   item = '0;
    logic                 busy;
    logic                 result_valid;
    psb_pkg::psb_result_t result;

    queued_req_t          request_queue[$];
    psb_pkg::psb_result_t primes_due[$];

    queued_req_t staged;
    bit          have_staged = 1'b0;
    bit          on_port = 1'b0;
    logic        took = 1'b0;
    int          quiet_left = 0;
    int          requests_total = 0;
    int          requests_taken = 0;
    int          mismatches = 0;
    longint      cycles = 0;
    longint      work_estimate = 0;

    // Search state of the predictor; it does not feed the outputs.
    logic [VALUE_BITS-1:0] last_candidate = '0;
    logic [15:0]           last_divisor = '0;
    logic [COUNT_BITS-1:0] primes_found = '0;

    prime_search_below_bound uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .item         (item),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result)
    );

    always #2 clk = ~clk;

    function automatic psb_pkg::psb_result_t make_result(input logic [VALUE_BITS-1:0] value,
                                                         input logic has, input logic last,
                                                         input logic short_run);
        psb_pkg::psb_result_t r;
        r.prime_value = value;
        r.has_prime   = has;
        r.last_of_run = last;
        r.shortfall   = short_run;
        return r;
    endfunction

    // Works out every result of one transaction and queues them in order.
    function automatic void search_primes(input psb_pkg::psb_item_t req);
        psb_pkg::psb_result_t run[$];
        psb_pkg::psb_result_t r;
        longint unsigned      c;
        longint unsigned      d;
        int                   want;
        bit                   is_prime;
        bit                   done;
        bit                   exhausted;
        want = int'(req.prime_count);
        if (want > MAX_PRIMES)
            want = MAX_PRIMES;
        primes_found = '0;
        done = 1'b0;
        exhausted = 1'b0;
        work_estimate += 16;
        if (want == 0)
            run.insert(run.size(), make_result('0, 1'b0, 1'b1, 1'b0));
        else if (req.start_value == 1 && want == 1)
        begin
            primes_found = COUNT_BITS'(1);
            run.insert(run.size(), make_result(VALUE_BITS'(1), 1'b1, 1'b1, 1'b0));
        end
        else if (req.start_value < 2)
        begin
            last_candidate = '0;
            run.insert(run.size(), make_result('0, 1'b0, 1'b1, 1'b1));
        end
        else
        begin
            c = 64'(req.start_value);
            c = c - 1;
            if (c[0] == 1'b0)
                c = c - 1;
            while (!done)
            begin
                last_candidate = c[VALUE_BITS-1:0];
                work_estimate += 8;
                // Candidates are always odd here, so only 1 needs ruling out up front.
                is_prime = (c >= 3);
                d = 3;
                while (is_prime && (d - 1) * (d - 1) < c)
                begin
                    last_divisor = d[15:0];
                    work_estimate += DIV_COST;
                    if (c % d == 0)
                        is_prime = 1'b0;
                    d += 2;
                end
                if (is_prime)
                begin
                    run.insert(run.size(), make_result(c[VALUE_BITS-1:0], 1'b1, 1'b0, 1'b0));
                    primes_found = COUNT_BITS'(run.size());
                end
                if (is_prime && run.size() >= want)
                    done = 1'b1;
                else if (c <= 2)
                begin
                    exhausted = 1'b1;
                    done = 1'b1;
                end
                else
                    c -= 2;
            end
            if (run.size() == 0)
                run.insert(run.size(), make_result('0, 1'b0, 1'b1, 1'b1));
            else
            begin
                r = run[run.size() - 1];
                r.last_of_run = 1'b1;
                r.shortfall = exhausted;
                run[run.size() - 1] = r;
            end
        end
        foreach (run[i])
            primes_due.insert(primes_due.size(), run[i]);
    endfunction

    task automatic add_request(input int unsigned bound, input int unsigned count,
                               input bit drain);
        queued_req_t q;
        q.req.start_value = bound[VALUE_BITS-1:0];
        q.req.prime_count = count[COUNT_BITS-1:0];
        q.drain = drain;
        if (quiet_left > 0)
        begin
            quiet_left--;
            q.gap = 0;
        end
        else
        begin
            q.gap = $urandom_range(0, GAP_MAX);
            if ($urandom_range(0, 19) == 0)
                quiet_left = $urandom_range(5, 15);
        end
        request_queue.insert(request_queue.size(), q);
        requests_total++;
    endtask

    // Driver: a transaction stays on the port until the edge that takes it.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (on_port && took)
                on_port = 1'b0;
            if (!on_port && !have_staged && request_queue.size() > 0)
            begin
                staged = request_queue.pop_front();
                have_staged = 1'b1;
            end
            if (!on_port && have_staged)
            begin
                if (staged.gap > 0)
                    staged.gap--;
                else if (!staged.drain || primes_due.size() == 0)
                begin
                    item <= staged.req;
                    on_port = 1'b1;
                    have_staged = 1'b0;
                end
            end
            start <= on_port;
        end
    end

    // Monitor: checks results, records accepted transactions and guards the run time.
    always @(posedge clk)
    begin
        psb_pkg::psb_result_t due;
        if (rst_n)
        begin
            cycles++;
            if (result_valid)
            begin
                if (primes_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result: value %0d has %0b last %0b short %0b",
                                 result.prime_value, result.has_prime, result.last_of_run,
                                 result.shortfall);
                end
                else
                begin
                    due = primes_due.pop_front();
                    if (result.prime_value !== due.prime_value
                        || result.has_prime !== due.has_prime
                        || result.last_of_run !== due.last_of_run
                        || result.shortfall !== due.shortfall)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                        begin
                            $write("mismatch: expected value %0d has %0b last %0b short %0b,",
                                   due.prime_value, due.has_prime, due.last_of_run,
                                   due.shortfall);
                            $display(" got value %0d has %0b last %0b short %0b",
                                     result.prime_value, result.has_prime,
                                     result.last_of_run, result.shortfall);
                        end
                    end
                end
            end
            if (start && !busy)
            begin
                search_primes(item);
                requests_taken++;
                took <= 1'b1;
            end
            else
                took <= 1'b0;
            if (cycles > 200000 + 4 * work_estimate)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        int sel;
        bit drain;
        add_request(32'h7FFF_FFFF, 1, 1'b0);
        add_request(0, 1, 1'b0);
        add_request(1, 1, 1'b0);
        add_request(1, 2, 1'b0);
        add_request(1, 0, 1'b0);
        add_request(2, 1, 1'b0);
        add_request(3, 1, 1'b0);
        add_request(4, 1, 1'b0);
        add_request(5, 3, 1'b0);
        add_request(98, 1, 1'b0);
        add_request(99, 2, 1'b0);
        add_request(10, 64, 1'b0);
        add_request(100, 127, 1'b0);
        add_request(300, 64, 1'b0);
        add_request(400, 64, 1'b0);
        add_request(1000, 0, 1'b0);
        add_request(12345, 5, 1'b1);
        add_request(1000000, 1, 1'b0);
        add_request(65, 65, 1'b0);
        for (int i = 0; i < 100; i++)
        begin
            sel = $urandom_range(0, 99);
            drain = ($urandom_range(0, 19) == 0);
            if (sel < 8)
                add_request($urandom_range(0, 5), $urandom_range(0, 3), drain);
            else if (sel < 14)
                add_request($urandom() & 32'h7FFF_FFFF, 0, drain);
            else if (sel < 17)
                add_request($urandom_range(1 << 16, 1 << 20), $urandom_range(1, 2), drain);
            else if (sel < 25)
                add_request($urandom_range(2, 300), $urandom_range(65, 127), drain);
            else if (sel < 40)
                add_request($urandom_range(2, 300), $urandom_range(9, 64), drain);
            else
                add_request($urandom_range(2, 2000), $urandom_range(1, 8), drain);
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        wait (requests_taken == requests_total);
        while (primes_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && primes_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> prime_search_below_bound.f
rtl/core/psb_pkg.sv
rtl/core/prime_search_below_bound.sv
rtl/core/psb_checker.sv
tb/tb.sv
